FILE: hw/rtl/rmic_pkg.sv
// ----------------------------------------------------------------------------
// rmic_pkg: shared definitions of the recursive exponential convolution block
// Widths of the data path, register indexes, sequencer codes and the control
// bundle that the sequencer broadcasts to the row of exponential cells.
// ----------------------------------------------------------------------------
package rmic_pkg;

  // Number of exponentials (one cell each) and length of a curve.
  localparam int NumExp      = 3;
  localparam int MaxChannels = 4096;

  // Field and data path widths.
  localparam int ChW       = 12;
  localparam int SampleW   = 16;
  localparam int HalfW     = 24;
  localparam int ScaledW   = 40;  // Q24.16 scaled sample
  localparam int RunW      = 48;  // Q32.16 running value
  localparam int DecayW    = 16;  // Q0.16
  localparam int AmpW      = 24;  // Q7.16 signed
  localparam int AmpSumW   = 26;  // Sum of up to three amplitudes
  localparam int MagW      = 25;  // Magnitude of an amplitude or of the sum
  localparam int TermW     = 58;  // Signed amplitude product
  localparam int SumW      = 60;  // Signed sum of all products
  localparam int OutW      = 48;  // Signed Q31.16 result
  localparam int CfgIdxW   = 4;
  localparam int CfgDataW  = 24;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] RegHalfStep = 4'd0;
  localparam logic [CfgIdxW-1:0] RegStart    = 4'd1;
  localparam logic [CfgIdxW-1:0] RegDecay0   = 4'd2;
  localparam logic [CfgIdxW-1:0] RegAmp0     = 4'd5;

  // Sequencer states; the cells act on the same codes.
  localparam int StateW = 3;
  localparam logic [StateW-1:0] StIdle  = 3'd0;
  localparam logic [StateW-1:0] StScale = 3'd1;
  localparam logic [StateW-1:0] StDec   = 3'd2;
  localparam logic [StateW-1:0] StAhi   = 3'd3;
  localparam logic [StateW-1:0] StAlo   = 3'd4;
  localparam logic [StateW-1:0] StSum   = 3'd5;
  localparam logic [StateW-1:0] StDone  = 3'd6;

  // Counter over the sum pass through the chain.
  localparam int SumCntW = (NumExp > 1) ? $clog2(NumExp) : 1;

  // Control bundle broadcast to every cell.
  typedef struct packed {
    logic [StateW-1:0] phase;
    logic              ch0;     // First channel: operand is the scaled sample
    logic              update;  // Recursion runs on this channel
    logic              clear;   // End of curve: running value returns to zero
  } cell_ctrl_t;

endpackage

FILE: hw/rtl/rmic_in_if.sv
// ----------------------------------------------------------------------------
// rmic_in_if: input channel of the convolution block
// One beat carries one instrument response sample and the end-of-curve flag.
// ----------------------------------------------------------------------------
interface rmic_in_if;
  logic                          valid;
  logic                          ready;
  logic [rmic_pkg::SampleW-1:0]  irf_sample;
  logic                          last;

  modport source (output valid, output irf_sample, output last, input ready);
  modport sink   (input valid, input irf_sample, input last, output ready);
endinterface

FILE: hw/rtl/rmic_out_if.sv
// ----------------------------------------------------------------------------
// rmic_out_if: output channel of the convolution block
// One beat carries one model sample with its channel index and final flag.
// ----------------------------------------------------------------------------
interface rmic_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [rmic_pkg::OutW-1:0] model_value;
  logic [rmic_pkg::ChW-1:0]         channel;
  logic                             final_res;

  modport source (output valid, output model_value, output channel, output final_res,
                  input ready);
  modport sink   (input valid, input model_value, input channel, input final_res,
                  output ready);
endinterface

FILE: hw/rtl/rmic_cell.sv
// ----------------------------------------------------------------------------
// rmic_cell: one exponential of the convolution
// Holds the running value of its exponential, performs the decay step and the
// amplitude product, and adds its term to the partial sum of its left neighbor.
// ----------------------------------------------------------------------------
module rmic_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rmic_pkg::cell_ctrl_t               ctrl_i,
  input  logic [rmic_pkg::DecayW-1:0]        decay_i,
  input  logic signed [rmic_pkg::AmpSumW-1:0] amp_i,
  input  logic [rmic_pkg::ScaledW-1:0]       prev_i,
  input  logic [rmic_pkg::ScaledW-1:0]       scaled_i,
  input  logic signed [rmic_pkg::SumW-1:0]   sum_i,
  output logic signed [rmic_pkg::SumW-1:0]   sum_o
);

  logic [rmic_pkg::RunW-1:0]          run_q;
  logic [rmic_pkg::RunW:0]            s_q;
  logic [rmic_pkg::RunW:0]            phi_q;
  logic signed [rmic_pkg::TermW-1:0]  term_q;
  logic signed [rmic_pkg::SumW-1:0]   sum_q;

  logic [rmic_pkg::RunW+rmic_pkg::DecayW:0] dec_prod;
  logic [rmic_pkg::RunW+1:0]                run_wide;
  logic [rmic_pkg::RunW-1:0]                run_d;
  logic [rmic_pkg::RunW-1:0]                operand;
  logic                                     neg;
  logic signed [rmic_pkg::AmpSumW-1:0]      amp_neg;
  logic [rmic_pkg::MagW-1:0]                mag;
  logic [rmic_pkg::RunW:0]                  phi_d;
  logic [rmic_pkg::RunW:0]                  plo;
  logic [rmic_pkg::TermW-2:0]               prod_mag;
  logic signed [rmic_pkg::TermW-1:0]        term_d;
  logic signed [rmic_pkg::SumW-1:0]         sum_d;

  // Decay step: floor(s * decay / 2^16) plus the scaled sample, saturated.
  assign dec_prod = (rmic_pkg::RunW+rmic_pkg::DecayW+1)'(s_q)
                  * (rmic_pkg::RunW+rmic_pkg::DecayW+1)'(decay_i);
  assign run_wide = (rmic_pkg::RunW+2)'(dec_prod[rmic_pkg::RunW+rmic_pkg::DecayW:16])
                  + (rmic_pkg::RunW+2)'(scaled_i);
  assign run_d    = (run_wide[rmic_pkg::RunW+1:rmic_pkg::RunW] != 2'b00) ?
                    {rmic_pkg::RunW{1'b1}} : run_wide[rmic_pkg::RunW-1:0];

  // Amplitude product on the magnitude, in two partial products.
  assign operand  = ctrl_i.ch0 ? rmic_pkg::RunW'(scaled_i) : run_q;
  assign neg      = amp_i[rmic_pkg::AmpSumW-1];
  assign amp_neg  = -amp_i;
  assign mag      = neg ? amp_neg[rmic_pkg::MagW-1:0] : amp_i[rmic_pkg::MagW-1:0];
  assign phi_d    = (rmic_pkg::RunW+1)'(operand[rmic_pkg::RunW-1:24])
                  * (rmic_pkg::RunW+1)'(mag);
  assign plo      = (rmic_pkg::RunW+1)'(operand[23:0]) * (rmic_pkg::RunW+1)'(mag);
  assign prod_mag = (rmic_pkg::TermW-1)'({phi_q, 8'b0})
                  + (rmic_pkg::TermW-1)'(plo[rmic_pkg::RunW:16]);
  assign term_d   = neg ? -$signed({1'b0, prod_mag}) : $signed({1'b0, prod_mag});

  // Partial sum handed on to the right neighbor.
  assign sum_d = sum_i + rmic_pkg::SumW'(term_q);
  assign sum_o = sum_q;

  // Running value of this exponential.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
    end else if (ctrl_i.clear) begin
      run_q <= '0;
    end else if (ctrl_i.phase == rmic_pkg::StDec && ctrl_i.update) begin
      run_q <= run_d;
    end
  end

  // Working registers of the cell, one step per sequencer phase.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.phase)
      rmic_pkg::StScale: s_q    <= (rmic_pkg::RunW+1)'(run_q) + (rmic_pkg::RunW+1)'(prev_i);
      rmic_pkg::StAhi:   phi_q  <= phi_d;
      rmic_pkg::StAlo:   term_q <= term_d;
      rmic_pkg::StSum:   sum_q  <= sum_d;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/recursive_multiexp_irf_convolution_top.sv
// ----------------------------------------------------------------------------
// recursive_multiexp_irf_convolution_top: multi-exponential IRF convolution
// Recursive trapezoidal convolution of an instrument response with a sum of
// exponential decays, one model sample per input sample.
// ----------------------------------------------------------------------------
// The block takes one instrument response count per input beat and returns one
// saturated Q31.16 model sample per beat, with its channel index and the final
// flag. It works on one sample at a time, in these steps: accept the beat, scale
// it by half the step, the decay step, the amplitude product, which is split
// into two partial products, the pass of the partial sum along the chain of
// cells, and the load of the output register. The next sample is accepted
// while a result still waits in the output register. Configuration is to be
// written by the user only while the block is idle; the block itself does not
// enforce this. A beat with the last flag set returns the running values, the
// previous sample and the channel counter to zero after its result is
// produced.
module recursive_multiexp_irf_convolution_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rmic_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [rmic_pkg::CfgDataW-1:0]   cfg_data_i,
  rmic_in_if.sink                         in_i,
  rmic_out_if.source                      out_o
);

  // Configuration registers.
  logic [rmic_pkg::HalfW-1:0]        half_q;
  logic [rmic_pkg::ChW-1:0]          start_q;
  logic [rmic_pkg::DecayW-1:0]       decay_q [rmic_pkg::NumExp];
  logic signed [rmic_pkg::AmpW-1:0]  amp_q   [rmic_pkg::NumExp];

  // Sequencer and curve state.
  logic [rmic_pkg::StateW-1:0]       state_q, state_d;
  logic [rmic_pkg::SumCntW-1:0]      sum_cnt_q;
  logic [rmic_pkg::ChW-1:0]          cnt_q;
  logic [rmic_pkg::ScaledW-1:0]      prev_q;

  // Item payload.
  logic [rmic_pkg::SampleW-1:0]      sample_q;
  logic                              last_q;
  logic [rmic_pkg::ScaledW-1:0]      scaled_q;

  // Output register.
  logic                              out_valid_q;
  logic signed [rmic_pkg::OutW-1:0]  out_value_q;
  logic [rmic_pkg::ChW-1:0]          out_ch_q;
  logic                              out_final_q;

  logic                              accept;
  logic                              finish;
  logic                              ch0;
  logic                              update;
  logic [rmic_pkg::ChW-1:0]          start_eff;
  logic signed [rmic_pkg::AmpSumW-1:0] amp_sum;
  logic signed [rmic_pkg::AmpSumW-1:0] cell_amp  [rmic_pkg::NumExp];
  logic signed [rmic_pkg::SumW-1:0]  chain_sum [rmic_pkg::NumExp+1];
  logic signed [rmic_pkg::SumW-1:0]  acc;
  logic signed [rmic_pkg::OutW-1:0]  result;
  rmic_pkg::cell_ctrl_t              ctrl;

  // Handshake.
  assign in_i.ready = (state_q == rmic_pkg::StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign finish     = (state_q == rmic_pkg::StDone) && (!out_valid_q || out_o.ready);

  // Channel classification.
  assign start_eff = (start_q == '0) ? rmic_pkg::ChW'(1) : start_q;
  assign ch0       = (cnt_q == '0);
  assign update    = !ch0 && (cnt_q >= start_eff);

  // Sum of the amplitudes for the first channel.
  always_comb begin
    amp_sum = '0;
    for (int k = 0; k < rmic_pkg::NumExp; k++) begin
      amp_sum = amp_sum + rmic_pkg::AmpSumW'(amp_q[k]);
    end
  end

  // Amplitude seen by each cell: the amplitude sum in the first cell on the
  // first channel, the own amplitude while the recursion runs, zero otherwise.
  always_comb begin
    for (int k = 0; k < rmic_pkg::NumExp; k++) begin
      if (ch0) begin
        cell_amp[k] = (k == 0) ? amp_sum : '0;
      end else if (update) begin
        cell_amp[k] = rmic_pkg::AmpSumW'(amp_q[k]);
      end else begin
        cell_amp[k] = '0;
      end
    end
  end

  assign ctrl.phase  = state_q;
  assign ctrl.ch0    = ch0;
  assign ctrl.update = update;
  assign ctrl.clear  = finish && last_q;

  // Row of exponential cells; the partial sum moves one cell per cycle.
  assign chain_sum[0] = '0;

  for (genvar k = 0; k < rmic_pkg::NumExp; k++) begin : g_cell
    rmic_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .decay_i  (decay_q[k]),
      .amp_i    (cell_amp[k]),
      .prev_i   (prev_q),
      .scaled_i (scaled_q),
      .sum_i    (chain_sum[k]),
      .sum_o    (chain_sum[k+1])
    );
  end

  // Saturation of the sum to the signed output range.
  assign acc = chain_sum[rmic_pkg::NumExp];

  always_comb begin
    if (acc[rmic_pkg::SumW-1:rmic_pkg::OutW-1] == '0 ||
        acc[rmic_pkg::SumW-1:rmic_pkg::OutW-1] == '1) begin
      result = acc[rmic_pkg::OutW-1:0];
    end else if (acc[rmic_pkg::SumW-1]) begin
      result = {1'b1, {(rmic_pkg::OutW-1){1'b0}}};
    end else begin
      result = {1'b0, {(rmic_pkg::OutW-1){1'b1}}};
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      rmic_pkg::StIdle:  if (accept) state_d = rmic_pkg::StScale;
      rmic_pkg::StScale: state_d = rmic_pkg::StDec;
      rmic_pkg::StDec:   state_d = rmic_pkg::StAhi;
      rmic_pkg::StAhi:   state_d = rmic_pkg::StAlo;
      rmic_pkg::StAlo:   state_d = rmic_pkg::StSum;
      rmic_pkg::StSum: begin
        if (sum_cnt_q == rmic_pkg::SumCntW'(rmic_pkg::NumExp - 1)) begin
          state_d = rmic_pkg::StDone;
        end
      end
      rmic_pkg::StDone:  if (finish) state_d = rmic_pkg::StIdle;
      default:           state_d = rmic_pkg::StIdle;
    endcase
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= rmic_pkg::HalfW'(32768);
      start_q <= rmic_pkg::ChW'(1);
      for (int k = 0; k < rmic_pkg::NumExp; k++) begin
        decay_q[k] <= '0;
        amp_q[k]   <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == rmic_pkg::RegHalfStep) begin
        half_q <= cfg_data_i[rmic_pkg::HalfW-1:0];
      end
      if (cfg_idx_i == rmic_pkg::RegStart) begin
        start_q <= cfg_data_i[rmic_pkg::ChW-1:0];
      end
      for (int k = 0; k < rmic_pkg::NumExp; k++) begin
        if (cfg_idx_i == rmic_pkg::RegDecay0 + rmic_pkg::CfgIdxW'(k)) begin
          decay_q[k] <= cfg_data_i[rmic_pkg::DecayW-1:0];
        end
        if (cfg_idx_i == rmic_pkg::RegAmp0 + rmic_pkg::CfgIdxW'(k)) begin
          amp_q[k] <= cfg_data_i[rmic_pkg::AmpW-1:0];
        end
      end
    end
  end

  // Sequencer, curve state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmic_pkg::StIdle;
      sum_cnt_q   <= '0;
      cnt_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rmic_pkg::StSum) begin
        sum_cnt_q <= sum_cnt_q + rmic_pkg::SumCntW'(1);
      end else begin
        sum_cnt_q <= '0;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
        if (last_q) begin
          cnt_q  <= '0;
          prev_q <= '0;
        end else begin
          prev_q <= scaled_q;
          if (cnt_q != rmic_pkg::ChW'(rmic_pkg::MaxChannels - 1)) begin
            cnt_q <= cnt_q + rmic_pkg::ChW'(1);
          end
        end
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload and output payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= in_i.irf_sample;
      last_q   <= in_i.last;
    end
    if (state_q == rmic_pkg::StScale) begin
      scaled_q <= rmic_pkg::ScaledW'(sample_q) * rmic_pkg::ScaledW'(half_q);
    end
    if (finish) begin
      out_value_q <= result;
      out_ch_q    <= cnt_q;
      out_final_q <= last_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.model_value = out_value_q;
  assign out_o.channel     = out_ch_q;
  assign out_o.final_res   = out_final_q;

endmodule

FILE: hw/rtl/rmic_checker.sv
// ----------------------------------------------------------------------------
// rmic_checker: port-level checks of the convolution block
// Watches the input and output channels and the number of samples in flight.
// ----------------------------------------------------------------------------
module rmic_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic signed [rmic_pkg::OutW-1:0] model_value_i,
  input logic [rmic_pkg::ChW-1:0]        channel_i,
  input logic                            final_res_i
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] pending_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Samples accepted whose results are not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(model_value_i) &&
    $stable(channel_i) && $stable(final_res_i))
    else $error("output beat changed while stalled");

  // One sample is worked on at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_i)
    else $error("input accepted again right after a beat");

  // No result beat without an accepted sample.
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat |-> pending_q != 2'd0)
    else $error("result beat without a pending sample");

  // At most one sample at work and one result waiting.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("too many samples in flight");

endmodule

bind recursive_multiexp_irf_convolution_top rmic_checker u_rmic_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .model_value_i (out_o.model_value),
  .channel_i     (out_o.channel),
  .final_res_i   (out_o.final_res)
);
